// File: rtl/etg_pkg.sv
// Shared types, constants and build-time math for the earcon tone generator.
package etg_pkg;

    typedef enum logic [2:0] {
        SND_CLICK,
        SND_TOGGLE,
        SND_SNAP,
        SND_ERROR,
        SND_SUCCESS,
        SND_FOCUS,
        SND_HOVER,
        SND_CHIME
    } sound_t;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_TRIGGER = 1'b1;

    localparam logic [1:0] CFG_MASTER_ENABLE = 2'd0;
    localparam logic [1:0] CFG_SOUND_MASK    = 2'd1;
    localparam logic [1:0] CFG_VOLUME        = 2'd2;

    localparam logic [15:0] UNITY      = 16'h8000;
    localparam logic [15:0] LFSR_SEED  = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS  = 16'hB400;
    localparam logic [7:0]  MASK_RESET = 8'h9F;

    // multiplier digit size, used by the serial multiplier
    localparam int DIGIT_BITS = 4;

    // Q30 odd polynomial for the first quarter wave
    localparam logic [63:0] C_A1 = 64'd1686629713;
    localparam logic [63:0] C_A3 = 64'd693598669;
    localparam logic [63:0] C_A5 = 64'd85569306;
    localparam logic [63:0] C_A7 = 64'd5026995;
    localparam logic [63:0] C_A9 = 64'd172272;

    // quarter-wave sine magnitude in Q1.15 for a Q30 angle fraction u
    function automatic logic [14:0] sine_q15(input logic [63:0] u);
        logic [63:0] u2;
        logic [63:0] p;
        logic [63:0] v;
        u2 = (u * u) >> 30;
        p  = C_A9;
        p  = C_A7 - ((p * u2) >> 30);
        p  = C_A5 - ((p * u2) >> 30);
        p  = C_A3 - ((p * u2) >> 30);
        p  = C_A1 - ((p * u2) >> 30);
        v  = (((p * u) >> 30) + 64'd16384) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[14:0];
    endfunction

    // Q1.31 truncated series for exp(-x), x given in Q1.31
    function automatic logic [31:0] decay_mult(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] t2;
        logic [63:0] t3;
        logic [63:0] t4;
        logic [63:0] m;
        x  = (x_in > 64'h8000_0000) ? 64'h8000_0000 : x_in;
        t2 = ((x * x) >> 31) / 2;
        t3 = ((t2 * x) >> 31) / 3;
        t4 = ((t3 * x) >> 31) / 4;
        m  = 64'h8000_0000 - x + t2 - t3 + t4;
        return m[31:0];
    endfunction

    function automatic logic [15:0] amp_q15(input sound_t snd);
        logic [15:0] a;
        case (snd)
            SND_CLICK:   a = 16'd9830;
            SND_TOGGLE:  a = 16'd6554;
            SND_SNAP:    a = 16'd4915;
            SND_ERROR:   a = 16'd8192;
            SND_SUCCESS: a = 16'd6554;
            SND_FOCUS:   a = 16'd3277;
            SND_HOVER:   a = 16'd1638;
            SND_CHIME:   a = 16'd1638;
            default:     a = 16'd0;
        endcase
        return a;
    endfunction

endpackage

// File: rtl/etg_serial_mul.sv
// Unsigned digit-serial multiplier, one radix-16 digit of b per cycle.
module etg_serial_mul #(
    parameter int A_WIDTH = 17,
    parameter int B_WIDTH = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [A_WIDTH-1:0]         a,
    input  logic [B_WIDTH-1:0]         b,
    output logic                       done,
    output logic [A_WIDTH+B_WIDTH-1:0] product
);

    localparam int DW    = etg_pkg::DIGIT_BITS;
    localparam int STEPS = B_WIDTH / DW;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int SW    = A_WIDTH + DW;

    logic [A_WIDTH-1:0] a_reg;
    logic [A_WIDTH-1:0] hi_reg;
    logic [B_WIDTH-1:0] lo_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [SW-1:0]      step_sum;

    // partial product of the low digit added to the running upper half
    assign step_sum = SW'(hi_reg) + SW'(a_reg) * SW'(lo_reg[DW-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg    <= a;
                hi_reg   <= '0;
                lo_reg   <= b;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                hi_reg  <= step_sum[SW-1:DW];
                lo_reg  <= {step_sum[DW-1:0], lo_reg[B_WIDTH-1:DW]};
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

// File: rtl/earcon_tone_generator_core.sv
// Earcon tone generator: alert-sound synthesizer producing one Q1.15 sample per tick.
//
//  Channel   Ports                                   Direction  Moves
//  cfg       cfg_wr_en, cfg_index, cfg_wr_data       in         register writes
//  s         s_valid/s_ready, s_opcode, s_sound_type in         tick or trigger request
//  m         m_valid/m_ready, m_sample, m_playing,   out        one sample per tick
//            m_last_sample
//
// A trigger request leaves the block idle; a tick while silent goes straight to the output
// state. A playing tick runs the sine lookup (one lane, three for the chime, none for the
// click), then the three radix-16 multiplies of the gain chain; the envelope update runs
// alongside on a second serial multiplier. One request is worked on at a time.
// Synchronous active-low reset; no clearing pass. A finished sample waits in the
// output register while the next request is accepted.
module earcon_tone_generator_core #(
    parameter int SAMPLE_RATE      = 48000,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS       = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic [2:0]         s_sound_type,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_sample,
    output logic               m_playing,
    output logic               m_last_sample
);

    localparam int LOG2D   = $clog2(SINE_TABLE_DEPTH);
    localparam int QUARTER = SINE_TABLE_DEPTH / 4;
    localparam int QW      = LOG2D - 2;

    localparam logic [14:0] LEN_CLICK  = 15'(SAMPLE_RATE / 50);
    localparam logic [14:0] LEN_TOGGLE = 15'(SAMPLE_RATE / 20);
    localparam logic [14:0] LEN_SNAP   = 15'(SAMPLE_RATE / 100);
    localparam logic [14:0] LEN_PAIR   = 15'((3 * SAMPLE_RATE) / 20);
    localparam logic [14:0] LEN_FOCUS  = 15'(SAMPLE_RATE / 200);
    localparam logic [14:0] LEN_HOVER  = 15'((3 * SAMPLE_RATE) / 1000);
    localparam logic [14:0] LEN_CHIME  = 15'((3 * SAMPLE_RATE) / 10);
    localparam logic [14:0] HALF_PAIR  = LEN_PAIR / 2;

    localparam logic [31:0] M_CLICK  = etg_pkg::decay_mult((64'd10 << 31) / LEN_CLICK);
    localparam logic [31:0] M_TOGGLE = etg_pkg::decay_mult((64'd60 << 31) / SAMPLE_RATE);
    localparam logic [31:0] M_SNAP   = etg_pkg::decay_mult((64'd200 << 31) / SAMPLE_RATE);
    localparam logic [31:0] M_PAIR   = etg_pkg::decay_mult((64'd15 << 31) / SAMPLE_RATE);
    localparam logic [31:0] M_FOCUS  = etg_pkg::decay_mult((64'd400 << 31) / SAMPLE_RATE);
    localparam logic [31:0] M_HOVER  = etg_pkg::decay_mult((64'd500 << 31) / SAMPLE_RATE);
    localparam logic [31:0] M_CHIME  = etg_pkg::decay_mult((64'd5 << 31) / SAMPLE_RATE);

    localparam logic [63:0] HALF_SR = 64'(SAMPLE_RATE / 2);
    localparam logic [PHASE_BITS-1:0] INC_300  =
        PHASE_BITS'(((64'd300 << PHASE_BITS) + HALF_SR) / SAMPLE_RATE);
    localparam logic [PHASE_BITS-1:0] INC_400  =
        PHASE_BITS'(((64'd400 << PHASE_BITS) + HALF_SR) / SAMPLE_RATE);
    localparam logic [PHASE_BITS-1:0] INC_523  =
        PHASE_BITS'(((64'd523 << PHASE_BITS) + HALF_SR) / SAMPLE_RATE);
    localparam logic [PHASE_BITS-1:0] INC_659  =
        PHASE_BITS'(((64'd659 << PHASE_BITS) + HALF_SR) / SAMPLE_RATE);
    localparam logic [PHASE_BITS-1:0] INC_784  =
        PHASE_BITS'(((64'd784 << PHASE_BITS) + HALF_SR) / SAMPLE_RATE);
    localparam logic [PHASE_BITS-1:0] INC_880  =
        PHASE_BITS'(((64'd880 << PHASE_BITS) + HALF_SR) / SAMPLE_RATE);
    localparam logic [PHASE_BITS-1:0] INC_1200 =
        PHASE_BITS'(((64'd1200 << PHASE_BITS) + HALF_SR) / SAMPLE_RATE);
    localparam logic [PHASE_BITS-1:0] INC_2000 =
        PHASE_BITS'(((64'd2000 << PHASE_BITS) + HALF_SR) / SAMPLE_RATE);
    localparam logic [PHASE_BITS-1:0] INC_3000 =
        PHASE_BITS'(((64'd3000 << PHASE_BITS) + HALF_SR) / SAMPLE_RATE);

    localparam logic [14:0] SINE_PEAK = etg_pkg::sine_q15(64'(QUARTER) << (32 - LOG2D));
    localparam logic [1:0]  LAST_STAGE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SINE,
        ST_ABS,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_FIN
    } state_t;

    state_t                  state_reg;
    logic                    master_enable_reg;
    logic [7:0]              sound_enable_mask_reg;
    logic [15:0]             volume_reg;
    logic                    active_reg;
    etg_pkg::sound_t         current_sound_reg;
    logic [14:0]             sample_count_reg;
    logic [PHASE_BITS-1:0]   phase_acc_reg [3];
    logic [15:0]             env_reg;
    logic [15:0]             lfsr_reg;
    logic [15:0]             gain_reg;
    logic                    m_valid_reg;
    logic [1:0]              lane_reg;
    logic [1:0]              stage_reg;
    logic                    second_reg;
    logic                    play_reg;
    logic signed [17:0]      osc_reg;
    logic signed [15:0]      sine_reg;
    logic [16:0]             mag_reg;
    logic                    neg_reg;
    logic [15:0]             m_sample_reg;
    logic                    m_playing_reg;
    logic                    m_last_reg;

    logic                    s_fire;
    logic                    m_fire;
    logic                    out_free;
    logic [14:0]             len_sel;
    logic [31:0]             m_sel;
    logic [PHASE_BITS-1:0]   inc_first;
    logic [PHASE_BITS-1:0]   inc_second;
    logic [PHASE_BITS-1:0]   inc_sel;
    logic [PHASE_BITS-1:0]   phase_sel;
    logic                    two_tone;
    logic                    is_chime;
    logic [1:0]              lane_count;
    logic                    last_hit;
    logic [15:0]             count_inc;

    logic [14:0]             sine_rom [QUARTER];
    logic [LOG2D-1:0]        tab_idx;
    logic [1:0]              quad;
    logic [QW-1:0]           low;
    logic [QW-1:0]           low_mirror;
    logic [14:0]             tab_mag;
    logic [15:0]             mag16;
    logic [15:0]             sine_lut;

    logic                    smul_start;
    logic [15:0]             smul_b;
    logic                    smul_done;
    logic [32:0]             smul_prod;
    logic [33:0]             smul_sum;
    logic [16:0]             smul_rnd;
    logic                    emul_start;
    logic                    emul_done;
    logic [47:0]             emul_prod;
    logic [48:0]             emul_sum;
    logic [15:0]             env_new;

    logic [15:0]             sample_pos;
    logic [15:0]             sample_neg;
    logic [15:0]             lfsr_next;
    logic [15:0]             gain_clamped;

    // quarter-wave table, built at elaboration
    for (genvar g = 0; g < QUARTER; g++) begin : g_rom
        assign sine_rom[g] = etg_pkg::sine_q15(64'(g) << (32 - LOG2D));
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid & s_ready;
    assign m_fire   = m_valid_reg & m_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        case (current_sound_reg)
            etg_pkg::SND_CLICK: begin
                len_sel = LEN_CLICK;  m_sel = M_CLICK;
                inc_first = '0;       inc_second = '0;
            end
            etg_pkg::SND_TOGGLE: begin
                len_sel = LEN_TOGGLE; m_sel = M_TOGGLE;
                inc_first = INC_880;  inc_second = INC_880;
            end
            etg_pkg::SND_SNAP: begin
                len_sel = LEN_SNAP;   m_sel = M_SNAP;
                inc_first = INC_1200; inc_second = INC_1200;
            end
            etg_pkg::SND_ERROR: begin
                len_sel = LEN_PAIR;   m_sel = M_PAIR;
                inc_first = INC_400;  inc_second = INC_300;
            end
            etg_pkg::SND_SUCCESS: begin
                len_sel = LEN_PAIR;   m_sel = M_PAIR;
                inc_first = INC_523;  inc_second = INC_659;
            end
            etg_pkg::SND_FOCUS: begin
                len_sel = LEN_FOCUS;  m_sel = M_FOCUS;
                inc_first = INC_2000; inc_second = INC_2000;
            end
            etg_pkg::SND_HOVER: begin
                len_sel = LEN_HOVER;  m_sel = M_HOVER;
                inc_first = INC_3000; inc_second = INC_3000;
            end
            etg_pkg::SND_CHIME: begin
                len_sel = LEN_CHIME;  m_sel = M_CHIME;
                inc_first = INC_523;  inc_second = INC_523;
            end
            default: begin
                len_sel = LEN_CLICK;  m_sel = M_CLICK;
                inc_first = '0;       inc_second = '0;
            end
        endcase
    end

    assign two_tone   = (current_sound_reg == etg_pkg::SND_ERROR) ||
                        (current_sound_reg == etg_pkg::SND_SUCCESS);
    assign is_chime   = (current_sound_reg == etg_pkg::SND_CHIME);
    assign lane_count = is_chime ? 2'd3 : 2'd1;
    assign count_inc  = {1'b0, sample_count_reg} + 16'd1;
    assign last_hit   = (count_inc >= {1'b0, len_sel});

    // chord lanes each have their own pitch
    always_comb begin
        case (lane_reg)
            2'd0: begin
                phase_sel = phase_acc_reg[0];
                inc_sel   = is_chime ? INC_523 : (second_reg ? inc_second : inc_first);
            end
            2'd1: begin
                phase_sel = phase_acc_reg[1];
                inc_sel   = INC_659;
            end
            default: begin
                phase_sel = phase_acc_reg[2];
                inc_sel   = INC_784;
            end
        endcase
    end

    // table lookup with quarter-wave mirroring
    always_comb begin
        tab_idx    = phase_sel[PHASE_BITS-1 -: LOG2D];
        quad       = tab_idx[LOG2D-1 -: 2];
        low        = tab_idx[QW-1:0];
        low_mirror = ~low + QW'(1);
        if (quad[0]) begin
            tab_mag = (low == '0) ? SINE_PEAK : sine_rom[low_mirror];
        end else begin
            tab_mag = sine_rom[low];
        end
        mag16    = {1'b0, tab_mag};
        sine_lut = quad[1] ? (~mag16 + 16'd1) : mag16;
    end

    always_comb begin
        case (stage_reg)
            2'd0:    smul_b = env_reg;
            2'd1:    smul_b = etg_pkg::amp_q15(current_sound_reg);
            default: smul_b = gain_reg;
        endcase
    end

    assign smul_start = (state_reg == ST_MUL_GO);
    assign emul_start = (state_reg == ST_MUL_GO) && (stage_reg == 2'd0);

    etg_serial_mul #(
        .A_WIDTH (17),
        .B_WIDTH (16)
    ) u_gain_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (smul_start),
        .a       (mag_reg),
        .b       (smul_b),
        .done    (smul_done),
        .product (smul_prod)
    );

    etg_serial_mul #(
        .A_WIDTH (16),
        .B_WIDTH (32)
    ) u_env_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (emul_start),
        .a       (env_reg),
        .b       (m_sel),
        .done    (emul_done),
        .product (emul_prod)
    );

    // Q15 products round half away from zero on the magnitude
    assign smul_sum = {1'b0, smul_prod} + 34'd16384;
    assign smul_rnd = smul_sum[31:15];
    assign emul_sum = {1'b0, emul_prod} + 49'h0_4000_0000;
    assign env_new  = emul_sum[46:31];

    assign sample_pos = (mag_reg > 17'd32767) ? 16'h7FFF : mag_reg[15:0];
    assign sample_neg = (mag_reg > 17'd32768) ? 16'h8000 : (~mag_reg[15:0] + 16'd1);

    assign lfsr_next    = {1'b0, lfsr_reg[15:1]} ^ (lfsr_reg[0] ? etg_pkg::LFSR_TAPS : 16'h0000);
    assign gain_clamped = (volume_reg > etg_pkg::UNITY) ? etg_pkg::UNITY : volume_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg             <= ST_IDLE;
            master_enable_reg     <= 1'b1;
            sound_enable_mask_reg <= etg_pkg::MASK_RESET;
            volume_reg            <= etg_pkg::UNITY;
            active_reg            <= 1'b0;
            current_sound_reg     <= etg_pkg::SND_CLICK;
            sample_count_reg      <= '0;
            phase_acc_reg[0]      <= '0;
            phase_acc_reg[1]      <= '0;
            phase_acc_reg[2]      <= '0;
            env_reg               <= '0;
            lfsr_reg              <= etg_pkg::LFSR_SEED;
            gain_reg              <= '0;
            m_valid_reg           <= 1'b0;
            lane_reg              <= '0;
            stage_reg             <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    etg_pkg::CFG_MASTER_ENABLE: master_enable_reg     <= cfg_wr_data[0];
                    etg_pkg::CFG_SOUND_MASK:    sound_enable_mask_reg <= cfg_wr_data[7:0];
                    etg_pkg::CFG_VOLUME:        volume_reg            <= cfg_wr_data;
                    default: ;
                endcase
            end

            if (emul_done) begin
                env_reg <= env_new;
            end

            if (m_fire) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (s_opcode == etg_pkg::OP_TRIGGER) begin
                            if (master_enable_reg && sound_enable_mask_reg[s_sound_type]) begin
                                active_reg        <= 1'b1;
                                current_sound_reg <= etg_pkg::sound_t'(s_sound_type);
                                sample_count_reg  <= '0;
                                phase_acc_reg[0]  <= '0;
                                phase_acc_reg[1]  <= '0;
                                phase_acc_reg[2]  <= '0;
                                env_reg           <= etg_pkg::UNITY;
                                gain_reg          <= gain_clamped;
                            end
                        end else if (!active_reg) begin
                            mag_reg   <= '0;
                            neg_reg   <= 1'b0;
                            play_reg  <= 1'b0;
                            state_reg <= ST_FIN;
                        end else begin
                            play_reg   <= 1'b1;
                            second_reg <= two_tone && (sample_count_reg >= HALF_PAIR);
                            // pair sounds restart the envelope at the second tone
                            if (two_tone && (sample_count_reg == HALF_PAIR)) begin
                                env_reg <= etg_pkg::UNITY;
                            end
                            if (current_sound_reg == etg_pkg::SND_CLICK) begin
                                osc_reg   <= {{2{lfsr_reg[15]}}, lfsr_reg};
                                lfsr_reg  <= lfsr_next;
                                state_reg <= ST_ABS;
                            end else begin
                                osc_reg   <= '0;
                                lane_reg  <= '0;
                                state_reg <= ST_SINE;
                            end
                        end
                    end
                end
                ST_SINE: begin
                    // lookup of lane i overlaps accumulation of lane i-1
                    if (lane_reg != 2'd0) begin
                        osc_reg <= osc_reg + {{2{sine_reg[15]}}, sine_reg};
                    end
                    if (lane_reg != lane_count) begin
                        sine_reg                <= sine_lut;
                        phase_acc_reg[lane_reg] <= phase_sel + inc_sel;
                        lane_reg                <= lane_reg + 2'd1;
                    end else begin
                        state_reg <= ST_ABS;
                    end
                end
                ST_ABS: begin
                    neg_reg   <= osc_reg[17];
                    mag_reg   <= osc_reg[17] ? 17'(-osc_reg) : osc_reg[16:0];
                    stage_reg <= '0;
                    state_reg <= ST_MUL_GO;
                end
                ST_MUL_GO: begin
                    state_reg <= ST_MUL_WAIT;
                end
                ST_MUL_WAIT: begin
                    if (smul_done) begin
                        mag_reg <= smul_rnd;
                        if (stage_reg == LAST_STAGE) begin
                            state_reg <= ST_FIN;
                        end else begin
                            stage_reg <= stage_reg + 2'd1;
                            state_reg <= ST_MUL_GO;
                        end
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        m_sample_reg  <= neg_reg ? sample_neg : sample_pos;
                        m_playing_reg <= play_reg;
                        m_last_reg    <= play_reg && last_hit;
                        if (play_reg) begin
                            sample_count_reg <= count_inc[14:0];
                            if (last_hit) begin
                                active_reg <= 1'b0;
                            end
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_sample      = m_sample_reg;
    assign m_playing     = m_playing_reg;
    assign m_last_sample = m_last_reg;

endmodule

// File: tb/tone_sample_checker.sv
// Sample predictor and result checker for the earcon tone generator.
`timescale 1ns / 100ps

module tone_sample_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wr_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_opcode,
    input  logic [2:0]         s_sound_type,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_sample,
    input  logic               m_playing,
    input  logic               m_last_sample,
    output int                 mismatches,
    output int                 owed
);
    import etg_pkg::*;

    localparam longint unsigned RATE = 48000;
    localparam longint unsigned Q30  = 64'd1 << 30;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               playing;
        logic               last_sample;
    } tone_res_t;

    tone_res_t samples_due[$];

    // tables built once at start
    int              sine_rom   [0:1023];
    logic [31:0]     step_a     [0:7];
    logic [31:0]     step_b     [0:7];
    logic [31:0]     chime_step [0:2];
    longint unsigned fade       [0:7];
    longint unsigned dur        [0:7];
    longint unsigned gain_amp   [0:7];

    // register copy
    logic        reg_master;
    logic [7:0]  reg_mask;
    logic [15:0] reg_volume;

    // generator state
    logic            playing_now;
    sound_t          voice;
    longint unsigned count;
    logic [31:0]     phase [0:2];
    longint unsigned env;
    logic [15:0]     noise;
    longint unsigned gain;

    function automatic int sine_entry(int idx);
        logic [9:0]      i10;
        longint unsigned u;
        longint unsigned u2;
        longint unsigned p;
        longint unsigned v;
        i10 = idx[9:0];
        u = {34'd0, i10[7:0], 22'd0};
        if (i10[8]) begin
            u = Q30 - u;
        end
        u2 = (u * u) >> 30;
        p  = C_A9;
        p  = C_A7 - ((p * u2) >> 30);
        p  = C_A5 - ((p * u2) >> 30);
        p  = C_A3 - ((p * u2) >> 30);
        p  = C_A1 - ((p * u2) >> 30);
        v  = (((p * u) >> 30) + 64'd16384) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return i10[9] ? -int'(v) : int'(v);
    endfunction

    function automatic logic [31:0] tone_step(longint unsigned hz);
        return 32'(((hz << 32) + RATE / 2) / RATE);
    endfunction

    // per-sample exp(-r/d) as a 4th order series in Q1.31
    function automatic longint unsigned exp_series(longint unsigned r, longint unsigned d);
        longint unsigned x;
        longint unsigned t2;
        longint unsigned t3;
        longint unsigned t4;
        x = (r << 31) / d;
        if (x > 64'h8000_0000) begin
            x = 64'h8000_0000;
        end
        t2 = ((x * x) >> 31) / 2;
        t3 = ((t2 * x) >> 31) / 3;
        t4 = ((t3 * x) >> 31) / 4;
        return 64'h8000_0000 - x + t2 - t3 + t4;
    endfunction

    // Q15 product, rounded half away from zero
    function automatic longint q15_mul(longint a, longint unsigned b);
        longint unsigned mag;
        longint unsigned r;
        if (a < 0) begin
            mag = -a;
        end else begin
            mag = a;
        end
        r = (mag * b + 64'd16384) >> 15;
        if (a < 0) begin
            return -longint'(r);
        end
        return longint'(r);
    endfunction

    initial begin
        int hz_a   [0:7];
        int hz_b   [0:7];
        int rate_k [0:7];
        int num    [0:7];
        int den    [0:7];
        hz_a     = '{0, 880, 1200, 400, 523, 2000, 3000, 523};
        hz_b     = '{0, 880, 1200, 300, 659, 2000, 3000, 659};
        rate_k   = '{0, 60, 200, 15, 15, 400, 500, 5};
        num      = '{1, 1, 1, 3, 3, 1, 3, 3};
        den      = '{50, 20, 100, 20, 20, 200, 1000, 10};
        gain_amp = '{9830, 6554, 4915, 8192, 6554, 3277, 1638, 1638};
        for (int i = 0; i < 1024; i++) begin
            sine_rom[i] = sine_entry(i);
        end
        for (int s = 0; s < 8; s++) begin
            step_a[s] = tone_step(hz_a[s]);
            step_b[s] = tone_step(hz_b[s]);
            dur[s]    = (RATE * num[s]) / den[s];
            // click decays over its own length, the tones at a fixed rate
            if (sound_t'(s) == SND_CLICK) begin
                fade[s] = exp_series(10, dur[s]);
            end else begin
                fade[s] = exp_series(rate_k[s], RATE);
            end
        end
        chime_step[0] = tone_step(523);
        chime_step[1] = tone_step(659);
        chime_step[2] = tone_step(784);
    end

    task automatic tone_trigger(sound_t s);
        if (reg_master && reg_mask[s]) begin
            playing_now = 1'b1;
            voice       = s;
            count       = 0;
            phase[0]    = '0;
            phase[1]    = '0;
            phase[2]    = '0;
            env         = UNITY;
            gain        = (reg_volume > UNITY) ? UNITY : reg_volume;
        end
    endtask

    task automatic synth_tick();
        longint          osc;
        longint          val;
        longint unsigned half;
        logic            two_tone;
        logic            second;
        logic            fin;
        logic [15:0]     l;
        tone_res_t       r;
        r = '0;
        if (playing_now) begin
            half     = dur[voice] / 2;
            two_tone = (voice == SND_ERROR) || (voice == SND_SUCCESS);
            second   = two_tone && (count >= half);
            // second tone of a pair starts with a fresh envelope
            if (two_tone && count == half) begin
                env = UNITY;
            end
            case (voice)
                SND_CLICK: begin
                    l     = noise;
                    osc   = longint'($signed(l));
                    noise = (l >> 1) ^ (l[0] ? LFSR_TAPS : 16'h0000);
                end
                SND_CHIME: begin
                    osc = sine_rom[phase[0][31:22]] + sine_rom[phase[1][31:22]]
                        + sine_rom[phase[2][31:22]];
                    phase[0] = phase[0] + chime_step[0];
                    phase[1] = phase[1] + chime_step[1];
                    phase[2] = phase[2] + chime_step[2];
                end
                default: begin
                    osc      = sine_rom[phase[0][31:22]];
                    phase[0] = phase[0] + (second ? step_b[voice] : step_a[voice]);
                end
            endcase
            val = q15_mul(osc, env);
            val = q15_mul(val, gain_amp[voice]);
            val = q15_mul(val, gain);
            if (val > 32767) begin
                val = 32767;
            end
            if (val < -32768) begin
                val = -32768;
            end
            env   = ((env * fade[voice] + Q30) >> 31) & 64'hFFFF;
            fin   = (count + 1) >= dur[voice];
            count = (count + 1) & 64'h7FFF;
            if (fin) begin
                playing_now = 1'b0;
            end
            r.sample      = val[15:0];
            r.playing     = 1'b1;
            r.last_sample = fin;
        end
        samples_due.push_back(r);
    endtask

    task automatic check_field(string what, longint want, longint got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 100) begin
                $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            end
        end
    endtask

    always @(posedge aclk) begin
        tone_res_t want;
        if (!aresetn) begin
            reg_master  = 1'b1;
            reg_mask    = MASK_RESET;
            reg_volume  = UNITY;
            playing_now = 1'b0;
            voice       = SND_CLICK;
            count       = 0;
            phase[0]    = '0;
            phase[1]    = '0;
            phase[2]    = '0;
            env         = 0;
            noise       = LFSR_SEED;
            gain        = 0;
            mismatches  = 0;
            samples_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MASTER_ENABLE: reg_master = cfg_wr_data[0];
                    CFG_SOUND_MASK:    reg_mask   = cfg_wr_data[7:0];
                    CFG_VOLUME:        reg_volume = cfg_wr_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (samples_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 100) begin
                        $display("%0t: sample expected none, got %0d playing %0b last %0b",
                                 $time, m_sample, m_playing, m_last_sample);
                    end
                end else begin
                    want = samples_due.pop_front();
                    check_field("sample", want.sample, m_sample);
                    check_field("playing", want.playing, m_playing);
                    check_field("last_sample", want.last_sample, m_last_sample);
                end
            end
            if (s_valid && s_ready) begin
                if (s_opcode == OP_TRIGGER) begin
                    tone_trigger(sound_t'(s_sound_type));
                end else begin
                    synth_tick();
                end
            end
        end
        owed = samples_due.size();
    end

endmodule

// File: tb/earcon_tone_generator_core_test.sv
// Top of the earcon tone generator test: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module earcon_tone_generator_core_test;
    import etg_pkg::*;

    localparam int         CYCLE_LIMIT = 1_500_000;
    localparam int         SETTLE      = 40;
    localparam logic [1:0] CFG_SPARE   = 2'd3;

    logic               aclk         = 1'b0;
    logic               aresetn      = 1'b0;
    logic               cfg_wr_en    = 1'b0;
    logic [1:0]         cfg_index    = '0;
    logic [15:0]        cfg_wr_data  = '0;
    logic               s_valid      = 1'b0;
    logic               s_opcode     = 1'b0;
    logic [2:0]         s_sound_type = '0;
    logic               m_ready      = 1'b0;
    logic               s_ready;
    logic               m_valid;
    logic signed [15:0] m_sample;
    logic               m_playing;
    logic               m_last_sample;

    int   mismatches;
    int   owed;
    int   cycles      = 0;
    int   useful      = 0;
    int   sender_calm = 0;
    bit   quiet       = 1'b0;
    bit   hold_req    = 1'b0;
    bit   hold_done   = 1'b0;
    logic       sh_master = 1'b1;
    logic [7:0] sh_mask   = MASK_RESET;

    always #1 aclk = ~aclk;

    earcon_tone_generator_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_sound_type  (s_sound_type),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample      (m_sample),
        .m_playing     (m_playing),
        .m_last_sample (m_last_sample)
    );

    tone_sample_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_sound_type  (s_sound_type),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample      (m_sample),
        .m_playing     (m_playing),
        .m_last_sample (m_last_sample),
        .mismatches    (mismatches),
        .owed          (owed)
    );

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: random stall bursts, calm stretches, one long hold
    initial begin
        int r;
        @(posedge aclk);
        forever begin
            r = $urandom_range(0, 99);
            if (quiet) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else if (hold_req && !hold_done) begin
                // block fills up and has to stall its input
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_done = 1'b1;
            end else if (r < 8) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end else if (r < 10) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(50, 200)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_req(logic op, logic [2:0] snd);
        int r;
        if (!quiet) begin
            if (sender_calm > 0) begin
                sender_calm--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    sender_calm = $urandom_range(30, 150);
                end else if (r < 15) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 19)) @(posedge aclk);
                end
            end
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_sound_type <= snd;
        do @(posedge aclk); while (!s_ready);
        if (op == OP_TICK || (sh_master && sh_mask[snd])) begin
            useful++;
        end
    endtask

    // wait until every sample is back and the block has gone quiet
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (owed == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
    endtask

    task automatic configure(logic me, logic [7:0] mk, logic [15:0] vol);
        settle();
        write_reg(CFG_MASTER_ENABLE, {15'($urandom), me});
        write_reg(CFG_SOUND_MASK, {8'($urandom), mk});
        write_reg(CFG_VOLUME, vol);
        write_reg(CFG_SPARE, 16'($urandom));
        cfg_wr_en <= 1'b0;
        sh_master = me;
        sh_mask   = mk;
    endtask

    function automatic int full_run_len(sound_t s);
        case (s)
            SND_HOVER: return 144;
            SND_FOCUS: return 240;
            SND_SNAP:  return 480;
            SND_CLICK: return 960;
            default:   return 0;
        endcase
    endfunction

    // sounds started and ticked, short ones often played to their end
    task automatic run_phase(int budget);
        int     start;
        int     n;
        sound_t s;
        start = useful;
        while (useful - start < budget) begin
            case ($urandom_range(0, 9))
                0, 1:    s = SND_HOVER;
                2:       s = SND_FOCUS;
                3:       s = SND_SNAP;
                default: s = sound_t'($urandom_range(0, 7));
            endcase
            if ($urandom_range(0, 4) == 0) begin
                send_req(1'($urandom), 3'($urandom));
            end
            send_req(OP_TRIGGER, s);
            if (full_run_len(s) != 0 && $urandom_range(0, 2) == 0) begin
                n = full_run_len(s) + $urandom_range(0, 3);
            end else begin
                n = $urandom_range(1, 40);
            end
            repeat (n) begin
                if ($urandom_range(0, 149) == 0) begin
                    send_req(OP_TRIGGER, 3'($urandom));
                end
                send_req(OP_TICK, 3'($urandom));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_req(OP_TICK, SND_CHIME);       // idle tick
        send_req(OP_TRIGGER, SND_FOCUS);    // off in the reset mask
        send_req(OP_TICK, SND_CLICK);
        send_req(OP_TRIGGER, SND_CLICK);
        send_req(OP_TICK, SND_HOVER);
        send_req(OP_TICK, SND_CLICK);
        send_req(OP_TRIGGER, SND_SNAP);     // replaces the click
        send_req(OP_TICK, SND_ERROR);
        send_req(OP_TRIGGER, SND_HOVER);    // disabled, snap keeps going
        send_req(OP_TICK, SND_SUCCESS);
        configure(1'b0, MASK_RESET, UNITY);
        send_req(OP_TRIGGER, SND_TOGGLE);
        send_req(OP_TICK, SND_TOGGLE);
        configure(1'b1, 8'hFF, 16'hFFFF);   // volume above unity gets clamped
        for (int k = 0; k < 8; k++) begin
            send_req(OP_TRIGGER, sound_t'(k));
            send_req(OP_TICK, 3'($urandom));
        end

        configure(1'b1, 8'hFF, 16'($urandom_range(0, 32768)));
        run_phase(400);
        configure(1'b1, 8'hFF, 16'h0000);
        run_phase(100);
        configure(1'b1, 8'($urandom), 16'hFFFF);
        hold_req = 1'b1;
        run_phase(350);
        configure(1'b1, 8'hFF, 16'h0001);
        run_phase(100);
        configure(1'b0, 8'hFF, 16'($urandom));
        run_phase(60);

        // one two-tone sound carried past its half-way switch
        configure(1'b1, 8'hFF, UNITY);
        send_req(OP_TRIGGER, $urandom_range(0, 1) ? SND_ERROR : SND_SUCCESS);
        repeat (3600 + $urandom_range(8, 60)) begin
            send_req(OP_TICK, 3'($urandom));
        end

        configure(1'b1, 8'hFF, 16'($urandom));
        quiet = 1'b1;
        run_phase(400);
        settle();

        if (mismatches == 0 && owed == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
